### rtl/swr_pkg.sv
// ----------------------------------------------------------------------------
// swr_pkg
// Shared widths, register indexes and the job record passed from the window
// bookkeeping front end to the divide / square-root back end.
// ----------------------------------------------------------------------------
package swr_pkg;

  // Window storage and sample format
  localparam int WINDOW_DEPTH = 1024;
  localparam int SAMPLE_BITS  = 16;
  localparam int ADDR_W       = $clog2(WINDOW_DEPTH);
  localparam int CNT_W        = ADDR_W + 1;

  // Running totals: one square needs 2*S-1 bits, the window adds ADDR_W
  localparam int SQR_W = 2 * SAMPLE_BITS - 1;
  localparam int SQ_W  = SQR_W + ADDR_W;
  localparam int LIN_W = SAMPLE_BITS + ADDR_W;

  // Result fields
  localparam int MSQ_W  = 31;
  localparam int RMS_W  = 16;
  localparam int MEAN_W = SAMPLE_BITS;

  // Back end sequencing
  localparam int STEP_W = $clog2(SQ_W);

  // Configuration port
  localparam int WS_W      = 11;
  localparam int DATA_W    = 32;
  localparam int PADDR_W   = 3;
  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_WIN_LEN = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_AC_MODE = 1'b1;
  localparam logic [WS_W-1:0]      WS_RESET    = 11'd1024;

  // Operation codes
  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // Job queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);

  typedef struct packed {
    logic [SQ_W-1:0]         sq;
    logic signed [LIN_W-1:0] lin;
    logic [CNT_W-1:0]        n;
    logic                    full;
  } job_t;

endpackage

### rtl/sliding_window_rms.sv
// ----------------------------------------------------------------------------
// sliding_window_rms
// Moving-window RMS meter over signed 16-bit samples.
// Input queue: drive operation/sample and raise push; the item is taken on a
// clock edge with push high and full low. operation push adds a sample to a
// window of win_len samples (ring of 1024); clear empties the window.
// Result queue: while empty is low, mean_square, rms and window_full show the
// oldest result; pop with empty low takes it. One result per item, in order.
// Sequencing: the front end reads the ring, then updates the running sums
// for each sample item, and takes a clear while idle; the back end runs a
// 41-step divide and a 16-step root per item, plus a second 41-step divide
// for the mean in AC mode. The back end sets the sustained rate. A two-entry
// job queue and the output register keep the input open while a result
// waits; a stalled receiver backs up into full once both are occupied.
// Reset: window empty, window length 1024, AC mode off, no result pending.
// APB: window length at 0x0 (a write also empties the window), AC mode flag
// at 0x4; write only while the block is idle.
// ----------------------------------------------------------------------------
module sliding_window_rms
  import swr_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic                          operation,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  output logic                          empty,
  input  logic                          pop,
  output logic [MSQ_W-1:0]              mean_square,
  output logic [RMS_W-1:0]              rms,
  output logic                          window_full,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [PADDR_W-1:0]            paddr,
  input  logic [DATA_W-1:0]             pwdata,
  output logic [DATA_W-1:0]             prdata,
  output logic                          pready
);

  logic [WS_W-1:0]      win_len;
  logic                 ac_mode;
  logic                 cfg_wr;
  logic                 cfg_clear;
  logic [REG_IDX_W-1:0] reg_idx;
  logic [CNT_W-1:0]     win;

  logic                 q_push;
  logic                 q_pop;
  logic                 q_full;
  logic                 q_empty;
  job_t                 q_in;
  job_t                 q_out;

  // Register access
  assign pready    = 1'b1;
  assign reg_idx   = paddr[PADDR_W-1:2];
  assign cfg_wr    = psel && penable && pwrite;
  assign cfg_clear = cfg_wr && (reg_idx == REG_WIN_LEN);

  always_ff @(posedge clk) begin
    if (rst) begin
      win_len <= WS_RESET;
      ac_mode <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_WIN_LEN: win_len <= pwdata[WS_W-1:0];
        REG_AC_MODE: ac_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_WIN_LEN: prdata = {{(DATA_W - WS_W){1'b0}}, win_len};
      REG_AC_MODE: prdata = {{(DATA_W - 1){1'b0}}, ac_mode};
      default:     prdata = '0;
    endcase
  end

  // Effective window: zero acts as one, saturate at the ring depth
  always_comb begin
    if (win_len == '0) begin
      win = CNT_W'(1);
    end else if (int'(win_len) > WINDOW_DEPTH) begin
      win = CNT_W'(WINDOW_DEPTH);
    end else begin
      win = CNT_W'(win_len);
    end
  end

  swr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .operation (operation),
    .sample    (sample),
    .win       (win),
    .cfg_clear (cfg_clear),
    .q_push    (q_push),
    .q_job     (q_in),
    .q_full    (q_full)
  );

  swr_fifo u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .job_in  (q_in),
    .full    (q_full),
    .pop     (q_pop),
    .job_out (q_out),
    .empty   (q_empty)
  );

  swr_back u_back (
    .clk         (clk),
    .rst         (rst),
    .ac_mode     (ac_mode),
    .job         (q_out),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .empty       (empty),
    .pop         (pop),
    .mean_square (mean_square),
    .rms         (rms),
    .window_full (window_full)
  );

endmodule

### rtl/swr_ram.sv
// ----------------------------------------------------------------------------
// swr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module swr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/swr_fifo.sv
// ----------------------------------------------------------------------------
// swr_fifo
// Short job queue that decouples window bookkeeping from the arithmetic.
// ----------------------------------------------------------------------------
module swr_fifo
  import swr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t job_in,
  output logic full,
  input  logic pop,
  output job_t job_out,
  output logic empty
);

  job_t               entries [Q_DEPTH];
  logic [Q_PTR_W-1:0] wptr;
  logic [Q_PTR_W-1:0] rptr;
  logic [Q_PTR_W:0]   count;

  assign full    = (count == (Q_PTR_W + 1)'(Q_DEPTH));
  assign empty   = (count == '0);
  assign job_out = entries[rptr];

  // Store on push
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= job_in;
    end
  end

  // Advance pointers and track fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/swr_front.sv
// ----------------------------------------------------------------------------
// swr_front
// Accepts items, keeps the sample ring and the running sums, and hands one
// job per item to the back end. A clear becomes a job with empty totals.
// ----------------------------------------------------------------------------
module swr_front
  import swr_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic                          operation,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic [CNT_W-1:0]              win,
  input  logic                          cfg_clear,
  output logic                          q_push,
  output job_t                          q_job,
  input  logic                          q_full
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_READ = 2'd1;
  localparam logic [1:0] F_SUM  = 2'd2;

  logic [1:0]                    state;
  logic [ADDR_W-1:0]             wp;
  logic [CNT_W-1:0]              taken;
  logic                          is_full;
  logic [SQ_W-1:0]               sq;
  logic signed [LIN_W-1:0]       lin;

  logic [ADDR_W-1:0]             addr_q;
  logic signed [SAMPLE_BITS-1:0] x_q;
  logic [SQR_W-1:0]              xsq;
  logic signed [SAMPLE_BITS-1:0] old_q;
  logic [SQR_W-1:0]              oldsq;

  logic                          accept;
  logic [ADDR_W-1:0]             addr;
  logic [CNT_W-1:0]              addr_inc;
  logic signed [2*SAMPLE_BITS-1:0] prod_x;
  logic signed [2*SAMPLE_BITS-1:0] prod_old;
  logic [SAMPLE_BITS-1:0]        rdata;
  logic [CNT_W-1:0]              taken_next;
  logic                          full_next;
  logic [SQ_W-1:0]               sq_next;
  logic signed [LIN_W-1:0]       lin_next;
  logic [SQ_W-1:0]               sq_drop;
  logic signed [LIN_W-1:0]       lin_drop;

  assign full   = (state != F_IDLE) || q_full;
  assign accept = push && !full;

  // Slot for this sample, and the one after it
  assign addr     = ({1'b0, wp} >= win) ? '0 : wp;
  assign addr_inc = {1'b0, addr} + 1'b1;

  assign prod_x   = sample * sample;
  assign prod_old = $signed(rdata) * $signed(rdata);

  swr_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (WINDOW_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (state == F_READ),
    .waddr (addr_q),
    .wdata (x_q),
    .raddr (addr),
    .rdata (rdata)
  );

  // Fold the new sample in, drop the evicted one once the window is full
  always_comb begin
    taken_next = (taken < win) ? taken + 1'b1 : taken;
    full_next  = is_full || (taken_next >= win);
    sq_drop    = is_full ? {{(SQ_W - SQR_W){1'b0}}, oldsq} : '0;
    lin_drop   = is_full ? {{(LIN_W - SAMPLE_BITS){old_q[SAMPLE_BITS-1]}}, old_q} : '0;
    sq_next    = sq + {{(SQ_W - SQR_W){1'b0}}, xsq} - sq_drop;
    lin_next   = lin + {{(LIN_W - SAMPLE_BITS){x_q[SAMPLE_BITS-1]}}, x_q} - lin_drop;
  end

  // Job to the back end: summed totals, or empty totals on clear
  always_comb begin
    q_push = (accept && (operation == OP_CLEAR)) || (state == F_SUM);
    if (state == F_SUM) begin
      q_job.sq   = sq_next;
      q_job.lin  = lin_next;
      q_job.n    = taken_next;
      q_job.full = full_next;
    end else begin
      q_job.sq   = '0;
      q_job.lin  = '0;
      q_job.n    = CNT_W'(1);
      q_job.full = 1'b0;
    end
  end

  // Sample datapath
  always_ff @(posedge clk) begin
    if (state == F_IDLE) begin
      addr_q <= addr;
      x_q    <= sample;
      xsq    <= prod_x[SQR_W-1:0];
    end
    if (state == F_READ) begin
      old_q <= $signed(rdata);
      oldsq <= prod_old[SQR_W-1:0];
    end
  end

  // Window bookkeeping and sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= F_IDLE;
      wp      <= '0;
      taken   <= '0;
      is_full <= 1'b0;
      sq      <= '0;
      lin     <= '0;
    end else if (cfg_clear) begin
      state   <= F_IDLE;
      wp      <= '0;
      taken   <= '0;
      is_full <= 1'b0;
      sq      <= '0;
      lin     <= '0;
    end else begin
      case (state)
        F_IDLE: begin
          if (accept) begin
            if (operation == OP_CLEAR) begin
              wp      <= '0;
              taken   <= '0;
              is_full <= 1'b0;
              sq      <= '0;
              lin     <= '0;
            end else begin
              wp    <= (addr_inc >= win) ? '0 : addr_inc[ADDR_W-1:0];
              state <= F_READ;
            end
          end
        end
        F_READ: begin
          state <= F_SUM;
        end
        F_SUM: begin
          taken   <= taken_next;
          is_full <= full_next;
          sq      <= sq_next;
          lin     <= lin_next;
          state   <= F_IDLE;
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/swr_back.sv
// ----------------------------------------------------------------------------
// swr_back
// Turns a job into a result: shared restoring divider for the mean square
// and the mean, one squaring multiply, clamp, then a digit-by-digit root.
// ----------------------------------------------------------------------------
module swr_back
  import swr_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             ac_mode,
  input  job_t             job,
  input  logic             q_empty,
  output logic             q_pop,
  output logic             empty,
  input  logic             pop,
  output logic [MSQ_W-1:0] mean_square,
  output logic [RMS_W-1:0] rms,
  output logic             window_full
);

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_DIV1 = 3'd1;
  localparam logic [2:0] B_DIV2 = 3'd2;
  localparam logic [2:0] B_MUL  = 3'd3;
  localparam logic [2:0] B_SUB  = 3'd4;
  localparam logic [2:0] B_SQRT = 3'd5;
  localparam logic [2:0] B_DONE = 3'd6;

  localparam int SRC_W = 2 * RMS_W;
  localparam int REM_W = RMS_W + 2;

  logic [2:0]              state;
  logic                    out_valid;
  logic [STEP_W-1:0]       cnt;

  logic [CNT_W-1:0]        n_q;
  logic signed [LIN_W-1:0] lin_q;
  logic                    full_q;
  logic [SQ_W-1:0]         dq;
  logic [CNT_W-1:0]        drem;
  logic [MSQ_W-1:0]        msq_q;
  logic [MEAN_W-1:0]       mean_q;
  logic [MSQ_W-1:0]        m2;
  logic [SRC_W-1:0]        ssrc;
  logic [REM_W-1:0]        srem;
  logic [RMS_W-1:0]        sroot;

  logic [CNT_W:0]          div_sh;
  logic                    div_ge;
  logic [CNT_W-1:0]        div_rem_next;
  logic [SQ_W-1:0]         div_q_next;
  logic [LIN_W-1:0]        lin_abs;
  logic [2*MEAN_W-1:0]     mean_prod;
  logic [MSQ_W-1:0]        msq_ac;
  logic [REM_W+1:0]        sq_sh;
  logic [REM_W+1:0]        sq_trial;
  logic                    sq_ge;
  logic [REM_W-1:0]        srem_next;
  logic                    slot_free;

  assign empty     = !out_valid;
  assign slot_free = !out_valid || pop;
  assign q_pop     = (state == B_IDLE) && !q_empty;

  // One restoring divide step
  always_comb begin
    div_sh       = {drem, dq[SQ_W-1]};
    div_ge       = (div_sh >= {1'b0, n_q});
    div_rem_next = div_ge ? CNT_W'(div_sh - {1'b0, n_q}) : div_sh[CNT_W-1:0];
    div_q_next   = {dq[SQ_W-2:0], div_ge};
  end

  // Mean magnitude, its square and the clamped difference
  assign lin_abs   = lin_q[LIN_W-1] ? LIN_W'(-lin_q) : LIN_W'(lin_q);
  assign mean_prod = mean_q * mean_q;
  assign msq_ac    = (msq_q > m2) ? msq_q - m2 : '0;

  // One root digit per step
  always_comb begin
    sq_sh     = {srem, ssrc[SRC_W-1 -: 2]};
    sq_trial  = {2'b00, sroot, 2'b01};
    sq_ge     = (sq_sh >= sq_trial);
    srem_next = sq_ge ? REM_W'(sq_sh - sq_trial) : sq_sh[REM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      // Drop the taken word unless a new one replaces it this cycle
      if (pop && out_valid && (state != B_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (!q_empty) begin
            dq     <= job.sq;
            drem   <= '0;
            n_q    <= job.n;
            lin_q  <= job.lin;
            full_q <= job.full;
            cnt    <= STEP_W'(SQ_W - 1);
            state  <= B_DIV1;
          end
        end
        B_DIV1: begin
          if (cnt == '0) begin
            msq_q <= div_q_next[MSQ_W-1:0];
            if (ac_mode) begin
              dq    <= {{(SQ_W - LIN_W){1'b0}}, lin_abs};
              drem  <= '0;
              cnt   <= STEP_W'(SQ_W - 1);
              state <= B_DIV2;
            end else begin
              m2    <= '0;
              state <= B_SUB;
            end
          end else begin
            dq   <= div_q_next;
            drem <= div_rem_next;
            cnt  <= cnt - 1'b1;
          end
        end
        B_DIV2: begin
          dq   <= div_q_next;
          drem <= div_rem_next;
          cnt  <= cnt - 1'b1;
          if (cnt == '0) begin
            mean_q <= div_q_next[MEAN_W-1:0];
            state  <= B_MUL;
          end
        end
        B_MUL: begin
          m2    <= mean_prod[MSQ_W-1:0];
          state <= B_SUB;
        end
        B_SUB: begin
          msq_q <= msq_ac;
          ssrc  <= {{(SRC_W - MSQ_W){1'b0}}, msq_ac};
          srem  <= '0;
          sroot <= '0;
          cnt   <= STEP_W'(RMS_W - 1);
          state <= B_SQRT;
        end
        B_SQRT: begin
          srem  <= srem_next;
          sroot <= {sroot[RMS_W-2:0], sq_ge};
          ssrc  <= {ssrc[SRC_W-3:0], 2'b00};
          cnt   <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= B_DONE;
          end
        end
        B_DONE: begin
          // Hold until the output register is free
          if (slot_free) begin
            mean_square <= msq_q;
            rms         <= sroot;
            window_full <= full_q;
            out_valid   <= 1'b1;
            state       <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

endmodule
